>>> rtl/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// shared types, constants and the divider step for the projection block
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int CoefW    = 32;
  localparam int ProdW    = 64;
  localparam int FracBits = 16;
  localparam int ClipW    = 50;   // clip-space sums, signed
  localparam int DivW     = 51;   // divider operands, unsigned
  localparam int QW       = 31;   // quotient and screen coordinate
  localparam int DivSteps = 30;   // bits of width << 16
  localparam int DimW     = 14;
  localparam int MidDepth = 4;
  localparam int MidAw    = 2;
  localparam int OutDepth = 2;
  localparam int OutAw    = 1;
  localparam int RegW     = 64;
  localparam int AddrW    = 6;

  localparam logic signed [ClipW-1:0] CullW  = ClipW'(6554);
  localparam logic [QW-1:0]           NegOne = 31'h7FFF0000;
  localparam logic [DimW-1:0]         WidthRst  = 14'd1920;
  localparam logic [DimW-1:0]         HeightRst = 14'd1080;

  typedef enum logic [2:0] {
    REG_ROW0_XY, REG_ROW0_ZW, REG_ROW1_XY, REG_ROW1_ZW,
    REG_ROW3_XY, REG_ROW3_ZW, REG_WIDTH, REG_HEIGHT
  } reg_idx_e;

  typedef struct packed {
    logic [RegW-1:0] r0xy, r0zw, r1xy, r1zw, r3xy, r3zw;
  } coef_t;

  // classified point handed from front to back
  typedef struct packed {
    logic [DivW-1:0] nx;
    logic [DivW-1:0] ny;
    logic [DivW-1:0] d;
    logic            vis;
  } job_t;

  typedef struct packed {
    logic [DivW-1:0] r;
    logic [QW-1:0]   q;
  } rq_t;

  typedef struct packed {
    job_t job;
    rq_t  x;
    rq_t  y;
  } stage_t;

  // one bit of floor(n * m / d), remainder stays below d
  function automatic rq_t div_step(rq_t cur, logic [DivW-1:0] n, logic [DivW-1:0] d,
                                   logic mbit);
    logic [DivW:0] t;
    rq_t           res;
    res.q = {cur.q[QW-2:0], 1'b0};
    t = {cur.r, 1'b0};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      res.q = res.q + {{(QW-1){1'b0}}, 1'b1};
    end
    if (mbit) begin
      t = t + {1'b0, n};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        res.q = res.q + {{(QW-1){1'b0}}, 1'b1};
      end
    end
    res.r = t[DivW-1:0];
    return res;
  endfunction

endpackage

>>> rtl/wtsp_front.sv
// ----------------------------------------------------------------------------
// wtsp_front
// matrix rows times point, clip sums, cull and screen tests (three stages)
// ----------------------------------------------------------------------------
module wtsp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      in_valid_i,
  input  logic signed [31:0]        world_x_i,
  input  logic signed [31:0]        world_y_i,
  input  logic signed [31:0]        world_z_i,
  input  wtsp_pkg::coef_t           coef_i,
  input  logic                      w_zero_i,
  input  logic                      h_zero_i,
  output logic                      job_valid_o,
  output wtsp_pkg::job_t            job_o
);

  logic signed [wtsp_pkg::ProdW-1:0] p_q [9];
  logic signed [wtsp_pkg::CoefW-1:0] c_q [3];
  logic signed [wtsp_pkg::ClipW-1:0] cx_q, cy_q, cw_q;
  logic                              v1_q, v2_q, v3_q;
  wtsp_pkg::job_t                    job_d, job_q;

  logic signed [wtsp_pkg::CoefW-1:0] m [12];
  assign m[0]  = $signed(coef_i.r0xy[31:0]);
  assign m[1]  = $signed(coef_i.r0xy[63:32]);
  assign m[2]  = $signed(coef_i.r0zw[31:0]);
  assign m[3]  = $signed(coef_i.r0zw[63:32]);
  assign m[4]  = $signed(coef_i.r1xy[31:0]);
  assign m[5]  = $signed(coef_i.r1xy[63:32]);
  assign m[6]  = $signed(coef_i.r1zw[31:0]);
  assign m[7]  = $signed(coef_i.r1zw[63:32]);
  assign m[8]  = $signed(coef_i.r3xy[31:0]);
  assign m[9]  = $signed(coef_i.r3xy[63:32]);
  assign m[10] = $signed(coef_i.r3zw[31:0]);
  assign m[11] = $signed(coef_i.r3zw[63:32]);

  // stage 1: nine products, exact Q32.32
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        p_q[3*r]   <= world_x_i * m[4*r];
        p_q[3*r+1] <= world_y_i * m[4*r+1];
        p_q[3*r+2] <= world_z_i * m[4*r+2];
        c_q[r]     <= m[4*r+3];
      end
    end
  end

  // stage 2: floored products plus translation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q <= wtsp_pkg::ClipW'(p_q[0] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(p_q[1] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(p_q[2] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(c_q[0]);
      cy_q <= wtsp_pkg::ClipW'(p_q[3] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(p_q[4] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(p_q[5] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(c_q[1]);
      cw_q <= wtsp_pkg::ClipW'(p_q[6] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(p_q[7] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(p_q[8] >>> wtsp_pkg::FracBits)
            + wtsp_pkg::ClipW'(c_q[2]);
    end
  end

  // stage 3: cull and screen window tests
  logic signed [wtsp_pkg::DivW-1:0] d_s, nx_s, ny_s;
  logic                             okx, oky, cull;
  always_comb begin
    d_s  = {cw_q, 1'b0};
    nx_s = {cx_q[wtsp_pkg::ClipW-1], cx_q} + {cw_q[wtsp_pkg::ClipW-1], cw_q};
    ny_s = {cw_q[wtsp_pkg::ClipW-1], cw_q} - {cy_q[wtsp_pkg::ClipW-1], cy_q};
    cull = cw_q < wtsp_pkg::CullW;
    okx  = w_zero_i || (!nx_s[wtsp_pkg::DivW-1] && nx_s <= d_s);
    oky  = h_zero_i || (!ny_s[wtsp_pkg::DivW-1] && ny_s <= d_s);
    job_d.nx  = nx_s;
    job_d.ny  = ny_s;
    job_d.d   = d_s;
    job_d.vis = !cull && okx && oky;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      job_q <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign job_valid_o = v3_q;
  assign job_o       = job_q;

endmodule

>>> rtl/wtsp_queue.sv
// ----------------------------------------------------------------------------
// wtsp_queue
// short flop queue of classified points between front and back
// ----------------------------------------------------------------------------
module wtsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  wtsp_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output wtsp_pkg::job_t data_o
);

  wtsp_pkg::job_t              mem_q [wtsp_pkg::MidDepth];
  logic [wtsp_pkg::MidAw-1:0]  wr_q, rd_q;
  logic [wtsp_pkg::MidAw:0]    cnt_q;

  assign full_o  = cnt_q == (wtsp_pkg::MidAw+1)'(wtsp_pkg::MidDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/wtsp_back.sv
// ----------------------------------------------------------------------------
// wtsp_back
// restoring scale-divide pipeline, one quotient bit per stage, result queue
// ----------------------------------------------------------------------------
module wtsp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  wtsp_pkg::job_t              job_i,
  output logic                        job_pop_o,
  input  logic [wtsp_pkg::DimW-1:0]   width_i,
  input  logic [wtsp_pkg::DimW-1:0]   height_i,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [wtsp_pkg::QW-1:0]     screen_x_o,
  output logic [wtsp_pkg::QW-1:0]     screen_y_o,
  output logic                        visible_o
);

  localparam int N = wtsp_pkg::DivSteps;

  wtsp_pkg::stage_t st_q [N];
  logic [N-1:0]     v_q;
  logic             en;

  // result queue
  logic [wtsp_pkg::QW-1:0]    ox_q [wtsp_pkg::OutDepth];
  logic [wtsp_pkg::QW-1:0]    oy_q [wtsp_pkg::OutDepth];
  logic                       ov_q [wtsp_pkg::OutDepth];
  logic [wtsp_pkg::OutAw-1:0] wr_q, rd_q;
  logic [wtsp_pkg::OutAw:0]   cnt_q;
  logic                       opush, opop;

  assign en        = cnt_q != (wtsp_pkg::OutAw+1)'(wtsp_pkg::OutDepth);
  assign job_pop_o = en && job_valid_i;

  // m = dim << 16: bit b of m is dim[b-16]
  function automatic logic mbit(logic [wtsp_pkg::DimW-1:0] dim, int b);
    logic r;
    r = 1'b0;
    if (b >= wtsp_pkg::FracBits) r = dim[b - wtsp_pkg::FracBits];
    return r;
  endfunction

  for (genvar k = 0; k < N; k++) begin : g_stage
    wtsp_pkg::stage_t cur, nxt;
    logic             vin;
    if (k == 0) begin : g_first
      always_comb begin
        cur     = '0;
        cur.job = job_i;
      end
      assign vin = job_valid_i;
    end else begin : g_rest
      assign cur = st_q[k-1];
      assign vin = v_q[k-1];
    end
    always_comb begin
      nxt     = cur;
      nxt.x   = wtsp_pkg::div_step(cur.x, cur.job.nx, cur.job.d, mbit(width_i, N-1-k));
      nxt.y   = wtsp_pkg::div_step(cur.y, cur.job.ny, cur.job.d, mbit(height_i, N-1-k));
    end
    always_ff @(posedge clk_i) begin
      if (en) st_q[k] <= nxt;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= vin;
      end
    end
  end

  assign opush = en && v_q[N-1];
  assign opop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (opush) begin
      ox_q[wr_q] <= st_q[N-1].job.vis ? st_q[N-1].x.q : wtsp_pkg::NegOne;
      oy_q[wr_q] <= st_q[N-1].job.vis ? st_q[N-1].y.q : wtsp_pkg::NegOne;
      ov_q[wr_q] <= st_q[N-1].job.vis;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (opush) wr_q <= wr_q + 1'b1;
      if (opop)  rd_q <= rd_q + 1'b1;
      if (opush && !opop) cnt_q <= cnt_q + 1'b1;
      else if (!opush && opop) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign empty_o    = cnt_q == '0;
  assign screen_x_o = ox_q[rd_q];
  assign screen_y_o = oy_q[rd_q];
  assign visible_o  = ov_q[rd_q];

endmodule

>>> rtl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// world_to_screen_projection
// perspective projection of Q16.16 world points to Q15.16 pixel coordinates
// ----------------------------------------------------------------------------
//  channel   | handshake             | beat
//  ----------+-----------------------+--------------------------------------
//  points in | push / full           | world_x_i, world_y_i, world_z_i
//  results   | empty / pop           | screen_x_o, screen_y_o, visible_o
//  registers | psel/penable/pwrite   | paddr 8*i, pwdata/prdata 64 bits
//
//  one point per cycle sustained when nothing stalls; a point passes 3 front
//  stages, the 4-deep middle queue, 30 divider stages (one quotient bit
//  each) and the result queue
//  the divider pipeline freezes while the 2-entry result queue is full,
//  the front freezes (full high) while the middle queue is full
//  reset clears the valid bits and queues; matrix resets to zero,
//  width to 1920 and height to 1080
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // point channel
  input  logic                          push,
  output logic                          full,
  input  logic signed [31:0]            world_x_i,
  input  logic signed [31:0]            world_y_i,
  input  logic signed [31:0]            world_z_i,
  // result channel
  output logic                          empty,
  input  logic                          pop,
  output logic signed [30:0]            screen_x_o,
  output logic signed [30:0]            screen_y_o,
  output logic                          visible_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wtsp_pkg::AddrW-1:0]    paddr,
  input  logic [wtsp_pkg::RegW-1:0]     pwdata,
  output logic [wtsp_pkg::RegW-1:0]     prdata,
  output logic                          pready
);

  // register file
  wtsp_pkg::coef_t                coef_q;
  logic [wtsp_pkg::DimW-1:0]      width_q, height_q;
  wtsp_pkg::reg_idx_e             idx;
  logic                           wr_en;

  assign pready = 1'b1;
  assign idx    = wtsp_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      width_q  <= wtsp_pkg::WidthRst;
      height_q <= wtsp_pkg::HeightRst;
    end else if (wr_en) begin
      case (idx)
        wtsp_pkg::REG_ROW0_XY: coef_q.r0xy <= pwdata;
        wtsp_pkg::REG_ROW0_ZW: coef_q.r0zw <= pwdata;
        wtsp_pkg::REG_ROW1_XY: coef_q.r1xy <= pwdata;
        wtsp_pkg::REG_ROW1_ZW: coef_q.r1zw <= pwdata;
        wtsp_pkg::REG_ROW3_XY: coef_q.r3xy <= pwdata;
        wtsp_pkg::REG_ROW3_ZW: coef_q.r3zw <= pwdata;
        wtsp_pkg::REG_WIDTH:   width_q     <= pwdata[wtsp_pkg::DimW-1:0];
        wtsp_pkg::REG_HEIGHT:  height_q    <= pwdata[wtsp_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      wtsp_pkg::REG_ROW0_XY: prdata = coef_q.r0xy;
      wtsp_pkg::REG_ROW0_ZW: prdata = coef_q.r0zw;
      wtsp_pkg::REG_ROW1_XY: prdata = coef_q.r1xy;
      wtsp_pkg::REG_ROW1_ZW: prdata = coef_q.r1zw;
      wtsp_pkg::REG_ROW3_XY: prdata = coef_q.r3xy;
      wtsp_pkg::REG_ROW3_ZW: prdata = coef_q.r3zw;
      wtsp_pkg::REG_WIDTH:   prdata = wtsp_pkg::RegW'(width_q);
      wtsp_pkg::REG_HEIGHT:  prdata = wtsp_pkg::RegW'(height_q);
      default:               prdata = '0;
    endcase
  end

  // front: accepts points while the middle queue has room
  logic           mid_full, mid_empty, mid_pop, job_valid;
  wtsp_pkg::job_t job, mid_job;
  logic           front_en;

  assign front_en = !mid_full;
  assign full     = !front_en;

  wtsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (front_en),
    .in_valid_i  (push && !full),
    .world_x_i   (world_x_i),
    .world_y_i   (world_y_i),
    .world_z_i   (world_z_i),
    .coef_i      (coef_q),
    .w_zero_i    (width_q == '0),
    .h_zero_i    (height_q == '0),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // a classified point leaves the front only when the front advances
  wtsp_queue u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid && front_en),
    .data_i  (job),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_job)
  );

  // back: divides and queues results
  logic [wtsp_pkg::QW-1:0] sx, sy;

  wtsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!mid_empty),
    .job_i       (mid_job),
    .job_pop_o   (mid_pop),
    .width_i     (width_q),
    .height_i    (height_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .screen_x_o  (sx),
    .screen_y_o  (sy),
    .visible_o   (visible_o)
  );

  assign screen_x_o = $signed(sx);
  assign screen_y_o = $signed(sy);

endmodule

>>> rtl/wtsp_checker.sv
// ----------------------------------------------------------------------------
// wtsp_checker
// port-level checks on the result channel of the projection block
// ----------------------------------------------------------------------------
module wtsp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [30:0] screen_x_o,
  input  logic signed [30:0] screen_y_o,
  input  logic               visible_o
);

  // a waiting beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(screen_x_o) && $stable(screen_y_o)
                       && $stable(visible_o))
    else $error("result beat changed while stalled");

  // rejected points report minus one on both axes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !visible_o |-> screen_x_o == $signed(wtsp_pkg::NegOne)
                          && screen_y_o == $signed(wtsp_pkg::NegOne))
    else $error("rejected point without -1.0 coordinates");

  // visible points land at non-negative pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && visible_o |-> !screen_x_o[30] && !screen_y_o[30])
    else $error("visible point with negative coordinate");

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (.*);
